// ===== design/bir_pkg.sv =====
// Shared types and constants for the bilinear image resampler.
`timescale 1ns / 1ps
`default_nettype none
package bir_pkg;

    localparam int DEF_MAX_WIDTH    = 256;
    localparam int DEF_MAX_HEIGHT   = 256;
    localparam int DEF_MAX_CHANNELS = 4;

    localparam int QUEUE_DEPTH = 4;
    localparam int OUT_DEPTH   = 4;

    localparam int FRAC_W = 17;

    localparam logic [2:0] CFG_SOURCE_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_SOURCE_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_CHANNEL_COUNT = 3'd2;
    localparam logic [2:0] CFG_SCALE_X       = 3'd3;
    localparam logic [2:0] CFG_SCALE_Y       = 3'd4;

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_READ,
        KIND_ZERO
    } bir_kind_t;

    typedef struct packed {
        logic [8:0]  source_width;
        logic [8:0]  source_height;
        logic [2:0]  channel_count;
        logic [23:0] scale_x;
        logic [23:0] scale_y;
    } bir_cfg_t;

endpackage
`default_nettype wire

// ===== design/bir_queue.sv =====
// Small show-ahead queue with push/full and pop/empty.
`timescale 1ns / 1ps
`default_nettype none
module bir_queue #(
    parameter int DEPTH = bir_pkg::QUEUE_DEPTH,
    parameter int W     = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic [W-1:0] wdata,
    input  wire logic         pop,
    output logic              empty,
    output logic [W-1:0]      rdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [0:DEPTH-1];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

// ===== design/bir_front.sv =====
// Front end: accepts words, maps coordinates and classifies them into queue entries.
`timescale 1ns / 1ps
`default_nettype none
module bir_front #(
    parameter int MAX_WIDTH    = bir_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = bir_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = bir_pkg::DEF_MAX_CHANNELS,
    parameter int ENTRY_W      = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bir_pkg::bir_cfg_t  cfg,
    input  wire logic               push,
    output logic                    full,
    input  wire logic               req_type,
    input  wire logic [7:0]         pos_x,
    input  wire logic [7:0]         pos_y,
    input  wire logic [1:0]         chan,
    input  wire logic [7:0]         pixel_in,
    output logic                    q_push,
    input  wire logic               q_full,
    output logic [ENTRY_W-1:0]      q_data
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int CW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int LW  = (XW > YW) ? XW : YW;
    localparam int WDW = $clog2(MAX_WIDTH + 1);
    localparam int HDW = $clog2(MAX_HEIGHT + 1);
    localparam int SW  = (WDW > HDW) ? WDW : HDW;
    localparam int NW  = $clog2(MAX_CHANNELS + 1);
    localparam int FW  = bir_pkg::FRAC_W;

    logic        a_valid_reg, a_valid_next;
    logic        b_valid_reg, b_valid_next;
    logic        a_type_reg;
    logic [7:0]  a_x_reg;
    logic [7:0]  a_y_reg;
    logic [1:0]  a_ch_reg;
    logic [7:0]  a_pix_reg;
    logic [32:0] a_prod_x_reg;
    logic [32:0] a_prod_y_reg;
    logic [ENTRY_W-1:0] b_data_reg, b_data_next;

    logic          b_free;
    logic          a_move;
    logic          a_free;
    logic          accept;
    logic          a_keep;
    logic [WDW-1:0] w_eff;
    logic [HDW-1:0] h_eff;
    logic [NW-1:0]  nc_eff;
    logic           ch_ok;
    logic [2*LW+FW-1:0] map_x;
    logic [2*LW+FW-1:0] map_y;
    bir_pkg::bir_kind_t kind;

    function automatic logic [2*LW+FW-1:0] map_axis(
        input logic [32:0]   prod,
        input logic [SW-1:0] size_m1
    );
        logic [33:0]   q;
        logic [16:0]   i;
        logic [LW-1:0] lo;
        logic [LW-1:0] hi;
        logic [FW-1:0] frac;
        q    = {1'b0, prod} - 34'd65536;
        i    = q[33:17];
        lo   = '0;
        hi   = '0;
        frac = '0;
        if (prod >= 33'd65536)
        begin
            if (32'(i) >= 32'(size_m1))
            begin
                lo = LW'(size_m1);
                hi = LW'(size_m1);
            end
            else
            begin
                lo   = LW'(i);
                hi   = LW'(i) + 1'b1;
                frac = q[FW-1:0];
            end
        end
        return {lo, hi, frac};
    endfunction

    assign b_free  = !b_valid_reg || !q_full;
    assign a_move  = a_valid_reg && b_free;
    assign a_free  = !a_valid_reg || a_move;
    assign full    = !a_free;
    assign accept  = push && a_free;
    assign q_push  = b_valid_reg;
    assign q_data  = b_data_reg;

    always_comb
    begin
        if (cfg.source_width == '0)
            w_eff = WDW'(1);
        else if (32'(cfg.source_width) > MAX_WIDTH)
            w_eff = WDW'(MAX_WIDTH);
        else
            w_eff = WDW'(cfg.source_width);
        if (cfg.source_height == '0)
            h_eff = HDW'(1);
        else if (32'(cfg.source_height) > MAX_HEIGHT)
            h_eff = HDW'(MAX_HEIGHT);
        else
            h_eff = HDW'(cfg.source_height);
        if (cfg.channel_count == '0)
            nc_eff = NW'(1);
        else if (32'(cfg.channel_count) > MAX_CHANNELS)
            nc_eff = NW'(MAX_CHANNELS);
        else
            nc_eff = NW'(cfg.channel_count);
    end

    always_comb
    begin
        ch_ok  = 32'(a_ch_reg) < 32'(nc_eff);
        map_x  = map_axis(a_prod_x_reg, SW'(w_eff - 1'b1));
        map_y  = map_axis(a_prod_y_reg, SW'(h_eff - 1'b1));
        a_keep = 1'b1;
        if (!a_type_reg)
        begin
            kind   = bir_pkg::KIND_WRITE;
            a_keep = ch_ok && (32'(a_x_reg) < MAX_WIDTH) && (32'(a_y_reg) < MAX_HEIGHT);
            b_data_next = {kind, a_pix_reg, {FW{1'b0}}, {FW{1'b0}},
                           CW'(a_ch_reg),
                           XW'(a_x_reg), XW'(a_x_reg),
                           YW'(a_y_reg), YW'(a_y_reg)};
        end
        else
        begin
            kind = ch_ok ? bir_pkg::KIND_READ : bir_pkg::KIND_ZERO;
            b_data_next = {kind, a_pix_reg,
                           map_x[FW-1:0], map_y[FW-1:0],
                           CW'(a_ch_reg),
                           XW'(map_x[2*LW+FW-1:LW+FW]), XW'(map_x[LW+FW-1:FW]),
                           YW'(map_y[2*LW+FW-1:LW+FW]), YW'(map_y[LW+FW-1:FW])};
        end
    end

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (accept)
            a_valid_next = 1'b1;
        else if (a_move)
            a_valid_next = 1'b0;
        b_valid_next = b_valid_reg;
        if (a_move)
            b_valid_next = a_keep;
        else if (b_free)
            b_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_type_reg   <= req_type;
            a_x_reg      <= pos_x;
            a_y_reg      <= pos_y;
            a_ch_reg     <= chan;
            a_pix_reg    <= pixel_in;
            a_prod_x_reg <= 33'(cfg.scale_x) * 33'({pos_x, 1'b1});
            a_prod_y_reg <= 33'(cfg.scale_y) * 33'({pos_y, 1'b1});
        end
        if (a_move)
        begin
            b_data_reg <= b_data_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/bir_back.sv =====
// Back end: pixel store, four-read sequencer, bilinear blend and result queue.
`timescale 1ns / 1ps
`default_nettype none
module bir_back #(
    parameter int MAX_WIDTH    = bir_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = bir_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = bir_pkg::DEF_MAX_CHANNELS,
    parameter int ENTRY_W      = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_empty,
    output logic                    q_pop,
    input  wire logic [ENTRY_W-1:0] q_data,
    output logic                    empty,
    input  wire logic               pop,
    output logic [7:0]              pixel_out
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int CW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int AW  = YW + XW + CW;
    localparam int FW  = bir_pkg::FRAC_W;
    localparam int KW  = $clog2(bir_pkg::OUT_DEPTH + 1);
    localparam logic [FW:0] ONE = {1'b1, {FW{1'b0}}};

    logic [1:0]    h_kind;
    logic [7:0]    h_pix;
    logic [FW-1:0] h_fx, h_fy;
    logic [CW-1:0] h_ch;
    logic [XW-1:0] h_x0, h_x1;
    logic [YW-1:0] h_y0, h_y1;

    logic          busy_reg, busy_next;
    logic [1:0]    phase_reg, phase_next;
    logic [FW-1:0] cur_fx_reg, cur_fy_reg;
    logic [CW-1:0] cur_ch_reg;
    logic [XW-1:0] cur_x0_reg, cur_x1_reg;
    logic [YW-1:0] cur_y0_reg, cur_y1_reg;
    logic [KW-1:0] credit_reg, credit_next;

    logic          take;
    logic          take_result;
    logic          mem_we;
    logic          rd_issue;
    logic [1:0]    rd_phase;
    logic [FW-1:0] rd_fx, rd_fy;
    logic [AW-1:0] mem_addr;
    logic [XW-1:0] sel_x;
    logic [YW-1:0] sel_y;
    logic [CW-1:0] sel_ch;

    logic [7:0]    mem_reg [0:(1 << AW)-1];
    logic [7:0]    mem_q_reg;

    logic          r_valid_reg, r_zero_reg;
    logic [1:0]    r_phase_reg;
    logic [FW-1:0] r_fx_reg, r_fy_reg;
    logic [7:0]    p00_reg, p10_reg;
    logic [24:0]   top_reg;
    logic [26:0]   blend_row;

    logic          b_valid_reg;
    logic [24:0]   b_top_reg, b_bot_reg;
    logic [FW-1:0] b_fy_reg;
    logic          c_valid_reg;
    logic [42:0]   c_p1_reg, c_p2_reg;
    logic [43:0]   d_sum;

    logic          out_full;

    assign {h_kind, h_pix, h_fx, h_fy, h_ch, h_x0, h_x1, h_y0, h_y1} = q_data;

    assign take        = !q_empty && !busy_reg &&
                         ((h_kind == bir_pkg::KIND_WRITE) ||
                          (credit_reg < KW'(bir_pkg::OUT_DEPTH)));
    assign take_result = take && (h_kind != bir_pkg::KIND_WRITE);
    assign q_pop       = take;
    assign mem_we      = take && (h_kind == bir_pkg::KIND_WRITE);
    assign rd_issue    = busy_reg || (take && (h_kind == bir_pkg::KIND_READ));

    always_comb
    begin
        if (busy_reg)
        begin
            rd_phase = phase_reg;
            rd_fx    = cur_fx_reg;
            rd_fy    = cur_fy_reg;
            sel_ch   = cur_ch_reg;
            sel_x    = phase_reg[0] ? cur_x1_reg : cur_x0_reg;
            sel_y    = phase_reg[1] ? cur_y1_reg : cur_y0_reg;
        end
        else
        begin
            rd_phase = 2'd0;
            rd_fx    = h_fx;
            rd_fy    = h_fy;
            sel_ch   = h_ch;
            sel_x    = h_x0;
            sel_y    = h_y0;
        end
        mem_addr = {sel_y, sel_x, sel_ch};
    end

    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        if (busy_reg)
        begin
            if (phase_reg == 2'd3)
                busy_next = 1'b0;
            phase_next = phase_reg + 1'b1;
        end
        else if (take && (h_kind == bir_pkg::KIND_READ))
        begin
            busy_next  = 1'b1;
            phase_next = 2'd1;
        end
        credit_next = credit_reg;
        if (take_result && !(pop && !empty))
            credit_next = credit_reg + 1'b1;
        else if (!take_result && pop && !empty)
            credit_next = credit_reg - 1'b1;
    end

    always_comb
    begin
        blend_row = 27'(p00_reg) * 27'(ONE - {1'b0, r_fx_reg})
                  + 27'(mem_q_reg) * 27'(r_fx_reg);
        if (r_phase_reg[1])
            blend_row = 27'(p10_reg) * 27'(ONE - {1'b0, r_fx_reg})
                      + 27'(mem_q_reg) * 27'(r_fx_reg);
        d_sum = {1'b0, c_p1_reg} + {1'b0, c_p2_reg} + (44'd1 << (2 * FW - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            phase_reg   <= 2'd0;
            credit_reg  <= '0;
            r_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg    <= busy_next;
            phase_reg   <= phase_next;
            credit_reg  <= credit_next;
            r_valid_reg <= rd_issue || (take && (h_kind == bir_pkg::KIND_ZERO));
            b_valid_reg <= r_valid_reg && (r_zero_reg || (r_phase_reg == 2'd3));
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem_reg[mem_addr] <= h_pix;
        else
            mem_q_reg <= mem_reg[mem_addr];

        if (take && (h_kind == bir_pkg::KIND_READ))
        begin
            cur_fx_reg <= h_fx;
            cur_fy_reg <= h_fy;
            cur_ch_reg <= h_ch;
            cur_x0_reg <= h_x0;
            cur_x1_reg <= h_x1;
            cur_y0_reg <= h_y0;
            cur_y1_reg <= h_y1;
        end

        r_zero_reg  <= !rd_issue;
        r_phase_reg <= rd_phase;
        r_fx_reg    <= rd_fx;
        r_fy_reg    <= rd_fy;

        if (r_valid_reg && !r_zero_reg)
        begin
            case (r_phase_reg)
                2'd0:    p00_reg <= mem_q_reg;
                2'd1:    top_reg <= blend_row[24:0];
                2'd2:    p10_reg <= mem_q_reg;
                default: ;
            endcase
        end

        if (r_valid_reg && r_zero_reg)
        begin
            b_top_reg <= '0;
            b_bot_reg <= '0;
            b_fy_reg  <= '0;
        end
        else
        begin
            b_top_reg <= top_reg;
            b_bot_reg <= blend_row[24:0];
            b_fy_reg  <= r_fy_reg;
        end

        c_p1_reg <= 43'(b_top_reg) * 43'(ONE - {1'b0, b_fy_reg});
        c_p2_reg <= 43'(b_bot_reg) * 43'(b_fy_reg);
    end

    bir_queue #(
        .DEPTH (bir_pkg::OUT_DEPTH),
        .W     (8)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (c_valid_reg),
        .full  (out_full),
        .wdata (d_sum[2*FW+7:2*FW]),
        .pop   (pop || (out_full && 1'b0)),
        .empty (empty),
        .rdata (pixel_out)
    );

endmodule
`default_nettype wire

// ===== design/bilinear_image_resampler.sv =====
// Top level of the bilinear image resampler: configuration registers and block wiring.
//
//  Channel   Handshake           Carries
//  input     push / full         req_type, pos_x, pos_y, chan, pixel_in
//  result    empty / pop         pixel_out
//  config    cfg_valid/cfg_ready cfg_index, cfg_data
//
// A pixel write uses the store port once; a request on a valid channel reads the
// single-ported pixel store four times, once per neighbor.
// Reset clears control state only; pixel store contents are undefined until written.
// The front end keeps taking words while the back end or the result side stalls,
// until the four-entry queue between them and the front end's registers fill.
`timescale 1ns / 1ps
`default_nettype none
module bilinear_image_resampler #(
    parameter int MAX_WIDTH    = bir_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = bir_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = bir_pkg::DEF_MAX_CHANNELS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        req_type,
    input  wire logic [7:0]  pos_x,
    input  wire logic [7:0]  pos_y,
    input  wire logic [1:0]  chan,
    input  wire logic [7:0]  pixel_in,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       pixel_out,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    localparam int XW      = $clog2(MAX_WIDTH);
    localparam int YW      = $clog2(MAX_HEIGHT);
    localparam int CW      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int ENTRY_W = 2 + 8 + 2 * bir_pkg::FRAC_W + CW + 2 * XW + 2 * YW;

    bir_pkg::bir_cfg_t    cfg_reg;
    logic                 q_push;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_empty;
    logic [ENTRY_W-1:0]   q_wdata;
    logic [ENTRY_W-1:0]   q_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_width  <= 9'd256;
            cfg_reg.source_height <= 9'd256;
            cfg_reg.channel_count <= 3'd3;
            cfg_reg.scale_x       <= 24'd65536;
            cfg_reg.scale_y       <= 24'd65536;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bir_pkg::CFG_SOURCE_WIDTH:  cfg_reg.source_width  <= cfg_data[8:0];
                bir_pkg::CFG_SOURCE_HEIGHT: cfg_reg.source_height <= cfg_data[8:0];
                bir_pkg::CFG_CHANNEL_COUNT: cfg_reg.channel_count <= cfg_data[2:0];
                bir_pkg::CFG_SCALE_X:       cfg_reg.scale_x       <= cfg_data;
                bir_pkg::CFG_SCALE_Y:       cfg_reg.scale_y       <= cfg_data;
                default: ;
            endcase
        end
    end

    bir_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_CHANNELS (MAX_CHANNELS),
        .ENTRY_W      (ENTRY_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .push     (push),
        .full     (full),
        .req_type (req_type),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .chan     (chan),
        .pixel_in (pixel_in),
        .q_push   (q_push),
        .q_full   (q_full),
        .q_data   (q_wdata)
    );

    bir_queue #(
        .DEPTH (bir_pkg::QUEUE_DEPTH),
        .W     (ENTRY_W)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .full  (q_full),
        .wdata (q_wdata),
        .pop   (q_pop),
        .empty (q_empty),
        .rdata (q_rdata)
    );

    bir_back #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_CHANNELS (MAX_CHANNELS),
        .ENTRY_W      (ENTRY_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_data    (q_rdata),
        .empty     (empty),
        .pop       (pop),
        .pixel_out (pixel_out)
    );

endmodule
`default_nettype wire

// ===== design/bir_checker.sv =====
// Port-level checks for the bilinear image resampler and their bind.
`timescale 1ns / 1ps
`default_nettype none
module bir_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       full,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] pixel_out,
    input wire logic       cfg_valid,
    input wire logic       cfg_ready
);

    a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("Configuration write was not taken.");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("Result word vanished before it was popped.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> $stable(pixel_out))
        else $error("Waiting result word changed.");

    a_reset_clean: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> (!full && empty))
        else $error("Block left reset with words pending.");

endmodule

bind bilinear_image_resampler bir_checker u_bir_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .pixel_out (pixel_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
`default_nettype wire
